// ===== sv/aes_be_pkg.sv =====
// Package for the AES block encrypt unit: S-box table, register indexes and
// the byte-level round functions. Depends on nothing; the top level uses it.
package aes_be_pkg;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] POLY_LOW = 8'h1b;

  typedef logic [127:0] state_t;
  typedef logic [31:0] word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of the state sits in bits 127-8i down; column c, row r is byte 4c+r.
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic state_t mix_cols(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// ===== sv/aes_plain_if.sv =====
// Input channel of the AES block encrypt unit: one plaintext block a word.
// Depends on nothing.
interface aes_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_upper;
  logic [63:0] plain_lower;
  modport source (output valid, plain_upper, plain_lower, input ready);
  modport sink (input valid, plain_upper, plain_lower, output ready);
endinterface

// ===== sv/aes_cipher_if.sv =====
// Output channel of the AES block encrypt unit: one ciphertext block a word.
// Depends on nothing.
interface aes_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_upper;
  logic [63:0] cipher_lower;
  modport source (output valid, cipher_upper, cipher_lower, input ready);
  modport sink (input valid, cipher_upper, cipher_lower, output ready);
endinterface

// ===== sv/aes_block_encrypt_unit.sv =====
// AES forward cipher, top level, with key schedule and round pipeline.
// Depends on aes_be_pkg, aes_plain_if and aes_cipher_if.
//
// The unit encrypts one 128-bit block per word with a 128, 192 or 256-bit
// key and takes a new block in every cycle unless the output stalls or the
// key schedule is being expanded. The initial key addition is registered
// in the first stage and the rounds are unrolled into SCHEDULE_WORDS/4 - 1
// further register stages; stages beyond the round count of a shorter key
// pass the state through unchanged. The whole pipeline advances together
// whenever the output register is empty or its word is being taken, so a
// stalled output holds every stage in place. The round keys live in
// flip-flops that every stage reads at fixed places. They are expanded by a
// sequencer that produces one schedule word per cycle from a sliding window
// of the last Nk words; after reset and after any write to a key or
// key-length register the input is held off through the load state and the
// derivation of every further word, counted from the last such write. A
// write that arrives while the schedule is still being expanded restarts
// the expansion. Key-length code three acts as a 256-bit key, and when the
// schedule store is too small for the chosen key the longest key length
// that fits is used. Register writes are to be made only while the unit
// holds no block in flight.
module aes_block_encrypt_unit #(
  parameter int SCHEDULE_WORDS = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  aes_plain_if.sink          plain,
  aes_cipher_if.source       cipher
);

  localparam int NR_STAGES = SCHEDULE_WORDS / 4 - 1;
  localparam int CW = $clog2(SCHEDULE_WORDS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // Configuration registers.
  logic [63:0] key_reg [4];
  logic [1:0]  mode;

  // Key schedule sequencer.
  logic [1:0]             state;
  logic [3:0]             nk;
  logic [3:0]             nk_next;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          total;
  logic [2:0]             ph;
  logic [7:0]             rc;
  aes_be_pkg::word_t      win [8];
  aes_be_pkg::word_t      rk [SCHEDULE_WORDS];
  aes_be_pkg::word_t      latest;
  aes_be_pkg::word_t      temp;
  aes_be_pkg::word_t      new_word;
  logic                   start;

  // Round pipeline.
  aes_be_pkg::state_t     stg_data [NR_STAGES + 1];
  logic [NR_STAGES:0]     vld;
  logic                   advance;
  logic [4:0]             nr;

  assign start = cfg_we && (cfg_index <= aes_be_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        key_reg[k] <= '0;
      end
      mode <= aes_be_pkg::MODE_128;
    end else if (cfg_we) begin
      case (cfg_index)
        aes_be_pkg::REG_KEY0: key_reg[0] <= cfg_wdata;
        aes_be_pkg::REG_KEY1: key_reg[1] <= cfg_wdata;
        aes_be_pkg::REG_KEY2: key_reg[2] <= cfg_wdata;
        aes_be_pkg::REG_KEY3: key_reg[3] <= cfg_wdata;
        aes_be_pkg::REG_MODE: mode <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Key words per block of the chosen length, cut back until it fits.
  always_comb begin
    if (mode != aes_be_pkg::MODE_128 && mode != aes_be_pkg::MODE_192 &&
        SCHEDULE_WORDS >= 60) begin
      nk_next = 4'd8;
    end else if (mode != aes_be_pkg::MODE_128 && SCHEDULE_WORDS >= 52) begin
      nk_next = 4'd6;
    end else begin
      nk_next = 4'd4;
    end
  end

  assign total  = CW'({3'b000, nk, 2'b00} + 9'd28);
  assign nr     = 5'(nk) + 5'd6;
  assign latest = (nk == 4'd4) ? win[3] : ((nk == 4'd6) ? win[5] : win[7]);

  always_comb begin
    temp = latest;
    if (ph == 3'd0) begin
      temp = aes_be_pkg::sub_word({latest[23:0], latest[31:24]}) ^ {rc, 24'h000000};
    end else if (nk == 4'd8 && ph == 3'd4) begin
      temp = aes_be_pkg::sub_word(latest);
    end
    new_word = win[0] ^ temp;
  end

  // A write to a key or key-length register in any state starts the expansion afresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      nk    <= 4'd4;
    end else if (start) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_IDLE: ;
        ST_LOAD: begin
          nk    <= nk_next;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (cnt == total - CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Window and store: in the load cycle the key words go in; afterwards the
  // window slides by one word and the newest word lands at position nk-1.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      for (int k = 0; k < 8; k++) begin
        win[k] <= (k % 2 == 0) ? key_reg[k / 2][63:32] : key_reg[k / 2][31:0];
        if (4'(k) < nk_next) begin
          rk[k] <= (k % 2 == 0) ? key_reg[k / 2][63:32] : key_reg[k / 2][31:0];
        end
      end
      cnt <= CW'(nk_next);
      ph  <= 3'd0;
      rc  <= aes_be_pkg::RCON_FIRST;
    end else if (state == ST_RUN) begin
      for (int k = 0; k < 7; k++) begin
        if (4'(k) == nk - 4'd1) begin
          win[k] <= new_word;
        end else begin
          win[k] <= win[k + 1];
        end
      end
      if (nk == 4'd8) begin
        win[7] <= new_word;
      end
      for (int k = 0; k < SCHEDULE_WORDS; k++) begin
        if (cnt == CW'(k)) begin
          rk[k] <= new_word;
        end
      end
      cnt <= cnt + CW'(1);
      ph  <= (ph == 3'(nk - 4'd1)) ? 3'd0 : ph + 3'd1;
      if (ph == 3'd0) begin
        rc <= aes_be_pkg::xtime(rc);
      end
    end
  end

  // Handshake: every stage moves when the output register is free or drains.
  assign advance     = !vld[NR_STAGES] || cipher.ready;
  assign plain.ready = advance && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= plain.valid && plain.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_data[0] <= {plain.plain_upper, plain.plain_lower} ^
                     {rk[0], rk[1], rk[2], rk[3]};
    end
  end

  for (genvar r = 1; r <= NR_STAGES; r++) begin : g_round
    aes_be_pkg::state_t ss;
    aes_be_pkg::state_t rkey;
    assign ss   = aes_be_pkg::sub_shift(stg_data[r - 1]);
    assign rkey = {rk[4 * r], rk[4 * r + 1], rk[4 * r + 2], rk[4 * r + 3]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[r] <= 1'b0;
      end else if (advance) begin
        vld[r] <= vld[r - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        if (5'(r) < nr) begin
          stg_data[r] <= aes_be_pkg::mix_cols(ss) ^ rkey;
        end else if (5'(r) == nr) begin
          stg_data[r] <= ss ^ rkey;
        end else begin
          stg_data[r] <= stg_data[r - 1];
        end
      end
    end
  end

  assign cipher.valid        = vld[NR_STAGES];
  assign cipher.cipher_upper = stg_data[NR_STAGES][127:64];
  assign cipher.cipher_lower = stg_data[NR_STAGES][63:0];

`ifndef SYNTHESIS
  a_reset_expands: assert property (@(posedge clk) rst |=> state == ST_LOAD)
    else $error("key expansion not started after reset");

  a_nk_legal: assert property (@(posedge clk) disable iff (rst)
    nk == 4'd4 || nk == 4'd6 || nk == 4'd8)
    else $error("key word count is not 4, 6 or 8");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt < CW'(SCHEDULE_WORDS))
    else $error("schedule sequencer ran past the store");

  a_empty_while_expanding: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> vld == '0)
    else $error("block in flight while the key schedule changes");
`endif

endmodule
